FILE: design/bffc_pkg.sv
package bffc_pkg;

  localparam int DEPTH_DEFAULT = 256;

  localparam logic [7:0] DELIM_RESET = 8'd10;

  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_STATUS = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] out_byte;
    logic [8:0] fill_count;
    logic       is_empty;
    logic       is_full;
    logic       frame_pending;
  } out_item_t;

  // Outcome of one request after the pointer stage, waiting for the read data.
  typedef struct packed {
    logic       status;
    logic       pop_ok;
    logic [8:0] fill;
    logic       empty;
    logic       full;
    logic [7:0] frames_in;
  } op_info_t;

endpackage

FILE: design/bffc_mem.sv
module bffc_mem import bffc_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_idx,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_idx,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/bffc_ctrl.sv
module bffc_ctrl import bffc_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  in_item_t      item,
  input  logic [7:0]    delimiter,
  output logic          wr_en,
  output logic [AW-1:0] wr_idx,
  output logic          rd_en,
  output logic [AW-1:0] rd_idx,
  output op_info_t      info
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    frames_in_r, frames_in_nxt;
  logic          push_ok, pop_ok, refused;

  assign push_ok = (item.mode == MODE_PUSH) && (count_r != FULL_CNT);
  assign pop_ok  = (item.mode == MODE_POP) && (count_r != '0);

  always_comb begin
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    count_nxt     = count_r;
    frames_in_nxt = frames_in_r;
    refused       = 1'b0;
    case (item.mode)
      MODE_PUSH: begin
        if (push_ok) begin
          wr_idx_nxt = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
          count_nxt  = count_r + 1'b1;
          if (item.in_byte == delimiter) begin
            frames_in_nxt = frames_in_r + 8'd1;
          end
        end else begin
          refused = 1'b1;
        end
      end
      MODE_POP: begin
        if (pop_ok) begin
          rd_idx_nxt = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
          count_nxt  = count_r - 1'b1;
        end else begin
          refused = 1'b1;
        end
      end
      MODE_CLEAR: begin
        rd_idx_nxt = wr_idx_r;
        count_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      count_r     <= '0;
      frames_in_r <= '0;
    end else if (accept) begin
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      count_r     <= count_nxt;
      frames_in_r <= frames_in_nxt;
    end
  end

  assign wr_en  = accept && push_ok;
  assign wr_idx = wr_idx_r;
  assign rd_en  = accept && pop_ok;
  assign rd_idx = rd_idx_r;

  always_comb begin
    info.status    = refused;
    info.pop_ok    = pop_ok;
    info.fill      = 9'(count_nxt);
    info.empty     = (count_nxt == '0);
    info.full      = (count_nxt == FULL_CNT);
    info.frames_in = frames_in_nxt;
  end

endmodule

FILE: design/bffc_out.sv
module bffc_out import bffc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       s1_valid,
  input  op_info_t   s1_info,
  input  logic [7:0] rd_data,
  input  logic [7:0] delimiter,
  output logic       s1_take,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  logic [7:0] frames_out_r, frames_out_nxt;
  logic       out_valid_r;
  out_item_t  out_data_r, out_data_nxt;

  assign s1_take = s1_valid && (!out_valid_r || out_ready);

  // The popped byte is only known here, so the frame-out count lives in this stage.
  always_comb begin
    frames_out_nxt = frames_out_r;
    if (s1_info.pop_ok && (rd_data == delimiter)) begin
      frames_out_nxt = frames_out_r + 8'd1;
    end
    out_data_nxt.status        = s1_info.status;
    out_data_nxt.out_byte      = s1_info.pop_ok ? rd_data : 8'd0;
    out_data_nxt.fill_count    = s1_info.fill;
    out_data_nxt.is_empty      = s1_info.empty;
    out_data_nxt.is_full       = s1_info.full;
    out_data_nxt.frame_pending = (s1_info.frames_in != frames_out_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_out_r <= '0;
      out_valid_r  <= 1'b0;
    end else if (s1_take) begin
      frames_out_r <= frames_out_nxt;
      out_valid_r  <= 1'b1;
    end else if (out_ready) begin
      out_valid_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/byte_fifo_with_frame_count.sv
// Byte FIFO for a serial receive path, with delimiter-based frame counting.
// Each request on the in_ channel carries a mode (push, pop, clear or status)
// and a byte for pushes. Every request yields exactly one result on the out_
// channel: refused flag, popped byte, fill count, empty/full flags and whether
// a frame (a delimiter seen on push but not yet on pop) is still pending.
// The delimiter value is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// A result passes the pointer update and memory read, then the result register.
// Throughput: one request per cycle while out_ready is high; the storage is a
// single-port-write, single-port-read memory with a registered read.
// When the receiver holds out_ready low, the result register and the stage in
// front of it fill up, and in_ready drops until a result is taken.
// Reset clears pointers, fill count, both frame counters and the output valid,
// and loads the delimiter with 10. The memory is not cleared; no clearing pass
// is needed, since only written entries are ever popped.
module byte_fifo_with_frame_count import bffc_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam int AW = $clog2(DEPTH);

  logic [7:0]    delim_r;
  logic          accept;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_idx, rd_idx;
  logic [7:0]    rd_data;
  op_info_t      info;
  logic          s1_valid_r;
  op_info_t      s1_info_r;
  logic          s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RESET;
    end else if (cfg_we) begin
      delim_r <= cfg_wdata;
    end
  end

  assign in_ready = !s1_valid_r || s1_take;
  assign accept   = in_valid && in_ready;

  bffc_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_data),
    .delimiter(delim_r),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .info     (info)
  );

  bffc_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_data(in_data.in_byte),
    .rd_en  (rd_en),
    .rd_idx (rd_idx),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= info;
    end
  end

  bffc_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1_info  (s1_info_r),
    .rd_data  (rd_data),
    .delimiter(delim_r),
    .s1_take  (s1_take),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
